>>> rtl/first_match_packet_filter_top_defines.svh
// Assertion macros shared by the packet filter's checker.
`ifndef FIRST_MATCH_PACKET_FILTER_TOP_DEFINES_SVH
`define FIRST_MATCH_PACKET_FILTER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define FMPF_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define FMPF_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/fmpf_pkg.sv
// Types, codes and helper functions of the first-match packet filter.
`default_nettype none
package fmpf_pkg;

   // Opcode of an input item
   localparam logic OP_WRITE    = 1'b0;
   localparam logic OP_CLASSIFY = 1'b1;

   // Direction code that disables a rule
   localparam logic [1:0] DIR_NONE = 2'd0;

   // IP protocol numbers seen on packets
   localparam logic [7:0] PROTO_TCP = 8'd6;
   localparam logic [7:0] PROTO_UDP = 8'd17;

   // Protocol selector held in a rule
   localparam logic [1:0] RPROTO_ANY = 2'd0;
   localparam logic [1:0] RPROTO_TCP = 2'd1;
   localparam logic [1:0] RPROTO_UDP = 2'd2;

   typedef struct packed {
      logic        opcode;
      logic [3:0]  rule_slot;
      logic [1:0]  direction;
      logic [7:0]  protocol;
      logic        rule_action;
      logic [31:0] src_addr;
      logic [31:0] src_mask;
      logic [15:0] source_port;
      logic [31:0] dst_addr;
      logic [31:0] dst_mask;
      logic [15:0] dst_port;
   } req_payload_type;

   typedef struct packed {
      logic       verdict;
      logic       matched;
      logic [3:0] match_slot;
   } rsp_payload_type;

   // Item as it travels along the cell chain: rule or packet plus running result
   typedef struct packed {
      logic        opcode;
      logic [3:0]  rule_slot;
      logic [1:0]  direction;
      logic [7:0]  protocol;
      logic        rule_action;
      logic [31:0] src_addr;
      logic [31:0] src_keep;
      logic [15:0] source_port;
      logic [31:0] dst_addr;
      logic [31:0] dst_keep;
      logic [15:0] dst_port;
      logic        hit;
      logic        verdict;
      logic [3:0]  hit_slot;
   } cell_item_type;

   // Control part of one stored rule
   typedef struct packed {
      logic       action;
      logic [1:0] proto_code;
      logic [1:0] direction;
   } rule_ctl_type;

   // Compare mask: bit i set when the mask has ones from bit 31 down to i.
   // An all-zero mask compares every bit.
   function automatic logic [31:0] keep_of_mask(input logic [31:0] mask);
      logic [31:0] t;
      t = mask;
      t = t & {1'b1, t[31:1]};
      t = t & {2'b11, t[31:2]};
      t = t & {4'hF, t[31:4]};
      t = t & {8'hFF, t[31:8]};
      t = t & {16'hFFFF, t[31:16]};
      if (mask == 32'd0) begin
         t = '1;
      end
      return t;
   endfunction

   // Rule protocol selector from the written protocol field
   function automatic logic [1:0] rule_proto_code(input logic [7:0] protocol);
      logic [1:0] code;
      code = RPROTO_ANY;
      if (protocol == 8'(RPROTO_TCP)) begin
         code = RPROTO_TCP;
      end else if (protocol == 8'(RPROTO_UDP)) begin
         code = RPROTO_UDP;
      end
      return code;
   endfunction

   // Address prefix compare; a rule address of zero matches anything
   function automatic logic addr_ok(input logic [31:0] pkt, input logic [31:0] rule,
                                    input logic [31:0] keep);
      return (rule == 32'd0) || (((pkt ^ rule) & keep) == 32'd0);
   endfunction

endpackage
`default_nettype wire

>>> rtl/fmpf_chan_if.sv
// Valid/ready channel carrying one payload item.
`default_nettype none
interface fmpf_chan_if #(parameter type PAYLOAD_TYPE = logic);
   logic        valid;
   logic        ready;
   PAYLOAD_TYPE payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> rtl/fmpf_cell.sv
// One cell of the filter chain: holds one rule and checks passing packets.
`default_nettype none
module fmpf_cell #(
   parameter int INDEX = 0
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          advance,
   input  wire                          in_valid,
   input  wire fmpf_pkg::cell_item_type in_item,
   output logic                         out_valid,
   output fmpf_pkg::cell_item_type      out_item
);

   logic                    valid_ff;
   fmpf_pkg::cell_item_type item_ff;
   fmpf_pkg::cell_item_type item_in;
   fmpf_pkg::rule_ctl_type  ctl_ff;
   fmpf_pkg::rule_ctl_type  ctl_in;
   logic [31:0]             src_addr_ff;
   logic [31:0]             src_keep_ff;
   logic [15:0]             source_port_ff;
   logic [31:0]             dst_addr_ff;
   logic [31:0]             dst_keep_ff;
   logic [15:0]             dst_port_ff;

   logic write_here;
   logic proto_ok;
   logic rule_hit;

   // rule write addressed to this cell
   assign write_here = advance && in_valid && (in_item.opcode == fmpf_pkg::OP_WRITE)
                       && (32'(in_item.rule_slot) == 32'(INDEX));

   assign ctl_in = '{action:     in_item.rule_action,
                     proto_code: fmpf_pkg::rule_proto_code(in_item.protocol),
                     direction:  in_item.direction};

   // protocol check of the stored rule
   always_comb begin
      case (ctl_ff.proto_code)
         fmpf_pkg::RPROTO_TCP: proto_ok = (in_item.protocol == fmpf_pkg::PROTO_TCP);
         fmpf_pkg::RPROTO_UDP: proto_ok = (in_item.protocol == fmpf_pkg::PROTO_UDP);
         default:              proto_ok = 1'b1;
      endcase
   end

   // first match: only a packet not yet decided upstream can hit here
   assign rule_hit = in_valid && (in_item.opcode == fmpf_pkg::OP_CLASSIFY) && !in_item.hit
                     && (ctl_ff.direction != fmpf_pkg::DIR_NONE)
                     && (ctl_ff.direction == in_item.direction)
                     && proto_ok
                     && fmpf_pkg::addr_ok(in_item.src_addr, src_addr_ff, src_keep_ff)
                     && fmpf_pkg::addr_ok(in_item.dst_addr, dst_addr_ff, dst_keep_ff)
                     && ((source_port_ff == 16'd0)
                         || (source_port_ff == in_item.source_port))
                     && ((dst_port_ff == 16'd0) || (dst_port_ff == in_item.dst_port));

   always_comb begin
      item_in = in_item;
      if (rule_hit) begin
         item_in.hit      = 1'b1;
         item_in.verdict  = ctl_ff.action;
         item_in.hit_slot = 4'(INDEX);
      end
   end

   // stage register towards the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance) begin
         item_ff <= item_in;
      end
   end

   // rule storage; reset disables the rule through its direction
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (write_here) begin
         ctl_ff <= ctl_in;
      end
      if (write_here) begin
         src_addr_ff    <= in_item.src_addr;
         src_keep_ff    <= in_item.src_keep;
         source_port_ff <= in_item.source_port;
         dst_addr_ff    <= in_item.dst_addr;
         dst_keep_ff    <= in_item.dst_keep;
         dst_port_ff    <= in_item.dst_port;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule
`default_nettype wire

>>> rtl/first_match_packet_filter_top.sv
// First-match packet filter: input stage, chain of rule cells and output register.
// Every item, rule write or packet, walks a chain of RULE_COUNT cells, one cell per
// cycle while the chain advances, so a rule write takes effect for exactly the
// packets accepted after it. Each cell holds one rule; the first cell whose rule
// matches stamps the verdict and slot into the packet, later cells pass it on. One
// item is accepted per cycle while the chain advances. A packet is registered by the
// first cell at acceptance, then by each further cell in turn and last by the output
// register. A rule write gives no result. When a result waits in the output register
// and the sink is not ready, the whole chain holds and no item is accepted. Reset
// disables every rule, so packets are accepted by default until rules are written;
// writes to a slot at or above RULE_COUNT are dropped.
`default_nettype none
module first_match_packet_filter_top #(
   parameter int RULE_COUNT = 16
) (
   input wire          clock,
   input wire          reset,
   fmpf_chan_if.sink   req_if,
   fmpf_chan_if.source rsp_if
);

   fmpf_pkg::req_payload_type req_data;
   fmpf_pkg::cell_item_type   entry_item;
   logic                      advance;
   logic                      no_ports;

   logic                      chain_valid [RULE_COUNT + 1];
   fmpf_pkg::cell_item_type   chain_item  [RULE_COUNT + 1];

   logic                      out_valid_ff;
   fmpf_pkg::rsp_payload_type out_data_ff;
   fmpf_pkg::cell_item_type   last_item;

   assign req_data = req_if.payload;

   // chain moves unless a result waits unread
   assign advance      = !out_valid_ff || rsp_if.ready;
   assign req_if.ready = advance;

   // ports of packets that are neither TCP nor UDP count as zero
   assign no_ports = (req_data.opcode == fmpf_pkg::OP_CLASSIFY)
                     && (req_data.protocol != fmpf_pkg::PROTO_TCP)
                     && (req_data.protocol != fmpf_pkg::PROTO_UDP);

   // entry: masks become compare masks, result starts as default accept
   always_comb begin
      entry_item.opcode      = req_data.opcode;
      entry_item.rule_slot   = req_data.rule_slot;
      entry_item.direction   = req_data.direction;
      entry_item.protocol    = req_data.protocol;
      entry_item.rule_action = req_data.rule_action;
      entry_item.src_addr    = req_data.src_addr;
      entry_item.src_keep    = fmpf_pkg::keep_of_mask(req_data.src_mask);
      entry_item.source_port = no_ports ? 16'd0 : req_data.source_port;
      entry_item.dst_addr    = req_data.dst_addr;
      entry_item.dst_keep    = fmpf_pkg::keep_of_mask(req_data.dst_mask);
      entry_item.dst_port    = no_ports ? 16'd0 : req_data.dst_port;
      entry_item.hit         = 1'b0;
      entry_item.verdict     = 1'b1;
      entry_item.hit_slot    = 4'd0;
   end

   assign chain_valid[0] = req_if.valid;
   assign chain_item[0]  = entry_item;

   // rule cells, slot 0 first
   for (genvar g = 0; g < RULE_COUNT; g++) begin : g_cell
      fmpf_cell #(
         .INDEX (g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (chain_valid[g]),
         .in_item   (chain_item[g]),
         .out_valid (chain_valid[g + 1]),
         .out_item  (chain_item[g + 1])
      );
   end

   assign last_item = chain_item[RULE_COUNT];

   // output register: packets only
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= chain_valid[RULE_COUNT]
                         && (last_item.opcode == fmpf_pkg::OP_CLASSIFY);
      end
      if (advance) begin
         out_data_ff.verdict    <= last_item.verdict;
         out_data_ff.matched    <= last_item.hit;
         out_data_ff.match_slot <= last_item.hit_slot;
      end
   end

   assign rsp_if.valid   = out_valid_ff;
   assign rsp_if.payload = out_data_ff;

endmodule
`default_nettype wire

>>> rtl/fmpf_checker.sv
// Port-level checks of the packet filter, bound to the top level.
`default_nettype none
`include "first_match_packet_filter_top_defines.svh"
module fmpf_checker (
   input wire       clock,
   input wire       reset,
   input wire       req_ready,
   input wire       rsp_valid,
   input wire       rsp_ready,
   input wire       verdict,
   input wire       matched,
   input wire [3:0] match_slot
);

   // a result offered and not taken stays offered
   `FMPF_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")

   // default accept carries slot zero
   `FMPF_ASSERT_NOW(a_default, rsp_valid && !matched, verdict && match_slot == 4'd0, "bad default")

   // input only stalls behind an unread result
   `FMPF_ASSERT_NOW(a_stall_cause, !req_ready, rsp_valid && !rsp_ready, "needless input stall")

   // a free output means the input is open
   `FMPF_ASSERT_NOW(a_open, !rsp_valid || rsp_ready, req_ready, "input closed with output free")

endmodule

bind first_match_packet_filter_top fmpf_checker u_fmpf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_if.ready),
   .rsp_valid  (rsp_if.valid),
   .rsp_ready  (rsp_if.ready),
   .verdict    (rsp_if.payload.verdict),
   .matched    (rsp_if.payload.matched),
   .match_slot (rsp_if.payload.match_slot)
);
`default_nettype wire

>>> verif/packet_verdict_checker.sv
// Checker for the packet filter: keeps its own rule table, predicts verdicts, compares.
`default_nettype none
module packet_verdict_checker #(
   parameter int RULE_COUNT = 16
) (
   input wire                            clock,
   input wire                            reset,
   input wire                            req_valid,
   input wire                            req_ready,
   input wire fmpf_pkg::req_payload_type req_payload,
   input wire                            rsp_valid,
   input wire                            rsp_ready,
   input wire fmpf_pkg::rsp_payload_type rsp_payload,
   output int                            failures,
   output int                            outstanding
);

   // One stored rule, with masks already reduced to prefix lengths
   typedef struct packed {
      logic [1:0]  direction;
      logic [1:0]  proto_sel;
      logic        action;
      logic [31:0] src_addr;
      logic [5:0]  src_len;
      logic [15:0] source_port;
      logic [31:0] dst_addr;
      logic [5:0]  dst_len;
      logic [15:0] dst_port;
   } filter_rule_type;

   filter_rule_type           rule_table [RULE_COUNT];
   fmpf_pkg::rsp_payload_type pending_verdicts [$];
   fmpf_pkg::rsp_payload_type expected_item;

   // Leading ones of a netmask; an all-zero mask means a full compare
   function automatic logic [5:0] prefix_length(input logic [31:0] mask);
      logic [5:0]  len;
      logic [31:0] m;
      len = '0;
      m = mask;
      if (mask == '0) begin
         return 6'd32;
      end
      while (len < 6'd32 && m[31]) begin
         len++;
         m = m << 1;
      end
      return len;
   endfunction

   // Zero rule address or zero prefix is a wildcard
   function automatic logic prefix_hit(input logic [31:0] pkt_addr, input logic [31:0] rule_addr,
                                       input logic [5:0] len);
      logic [31:0] keep;
      if (rule_addr == '0 || len == '0) begin
         return 1'b1;
      end
      keep = (len >= 6'd32) ? '1 : ~(32'hFFFF_FFFF >> len);
      return ((pkt_addr ^ rule_addr) & keep) == '0;
   endfunction

   function automatic void store_rule(input fmpf_pkg::req_payload_type wr);
      filter_rule_type r;
      r.direction = wr.direction;
      if (wr.protocol == 8'(fmpf_pkg::RPROTO_TCP)) begin
         r.proto_sel = fmpf_pkg::RPROTO_TCP;
      end else if (wr.protocol == 8'(fmpf_pkg::RPROTO_UDP)) begin
         r.proto_sel = fmpf_pkg::RPROTO_UDP;
      end else begin
         r.proto_sel = fmpf_pkg::RPROTO_ANY;
      end
      r.action      = wr.rule_action;
      r.src_addr    = wr.src_addr;
      r.src_len     = prefix_length(wr.src_mask);
      r.source_port = wr.source_port;
      r.dst_addr    = wr.dst_addr;
      r.dst_len     = prefix_length(wr.dst_mask);
      r.dst_port    = wr.dst_port;
      if (int'(wr.rule_slot) < RULE_COUNT) begin
         rule_table[wr.rule_slot] = r;
      end
   endfunction

   function automatic fmpf_pkg::rsp_payload_type classify_packet(
      input fmpf_pkg::req_payload_type pkt);
      fmpf_pkg::rsp_payload_type verdict_out;
      filter_rule_type           r;
      logic                      has_ports;
      logic [15:0]               sport;
      logic [15:0]               dport;
      has_ports = (pkt.protocol == fmpf_pkg::PROTO_TCP)
                  || (pkt.protocol == fmpf_pkg::PROTO_UDP);
      sport = has_ports ? pkt.source_port : '0;
      dport = has_ports ? pkt.dst_port : '0;
      // default accept when nothing matches
      verdict_out = '{verdict: 1'b1, matched: 1'b0, match_slot: '0};
      // scan from the top down so the lowest matching slot is the one left standing
      for (int i = RULE_COUNT - 1; i >= 0; i--) begin
         r = rule_table[i];
         if (r.direction != fmpf_pkg::DIR_NONE && r.direction == pkt.direction
             && !(r.proto_sel == fmpf_pkg::RPROTO_TCP && pkt.protocol != fmpf_pkg::PROTO_TCP)
             && !(r.proto_sel == fmpf_pkg::RPROTO_UDP && pkt.protocol != fmpf_pkg::PROTO_UDP)
             && prefix_hit(pkt.src_addr, r.src_addr, r.src_len)
             && prefix_hit(pkt.dst_addr, r.dst_addr, r.dst_len)
             && (r.source_port == '0 || r.source_port == sport)
             && (r.dst_port == '0 || r.dst_port == dport)) begin
            verdict_out = '{verdict: r.action, matched: 1'b1, match_slot: 4'(i)};
         end
      end
      return verdict_out;
   endfunction

   // Results are retired before new items are taken: a result never belongs to an item
   // accepted at the same edge
   always @(posedge clock) begin
      if (reset) begin
         foreach (rule_table[i]) begin
            rule_table[i] = '0;
         end
         pending_verdicts.delete();
         failures = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_verdicts.size() == 0) begin
               $error("result with no packet waiting: verdict %0d matched %0d slot %0d",
                      rsp_payload.verdict, rsp_payload.matched, rsp_payload.match_slot);
               failures++;
            end else begin
               expected_item = pending_verdicts.pop_front();
               if (rsp_payload.verdict !== expected_item.verdict) begin
                  $error("verdict: expected %0d, actual %0d",
                         expected_item.verdict, rsp_payload.verdict);
                  failures++;
               end
               if (rsp_payload.matched !== expected_item.matched) begin
                  $error("matched: expected %0d, actual %0d",
                         expected_item.matched, rsp_payload.matched);
                  failures++;
               end
               if (rsp_payload.match_slot !== expected_item.match_slot) begin
                  $error("match_slot: expected %0d, actual %0d",
                         expected_item.match_slot, rsp_payload.match_slot);
                  failures++;
               end
            end
         end
         if (req_valid && req_ready) begin
            if (req_payload.opcode == fmpf_pkg::OP_WRITE) begin
               store_rule(req_payload);
            end else begin
               pending_verdicts.push_back(classify_packet(req_payload));
            end
         end
      end
      outstanding = pending_verdicts.size();
   end

endmodule
`default_nettype wire

>>> verif/first_match_packet_filter_top_tb.sv
// Testbench top for the packet filter: clock, reset, stimulus, receiver and verdict.
`default_nettype none
module first_match_packet_filter_top_tb;

   localparam int RULE_COUNT       = 16;
   localparam int LONG_HOLD_CYCLES = 80;

   localparam logic [1:0] DIR_IN    = 2'd1;
   localparam logic [1:0] DIR_OUT   = 2'd2;
   localparam logic [1:0] DIR_ODD   = 2'd3;
   localparam logic [7:0] PROTO_ICMP = 8'd1;
   localparam logic       ACT_DROP   = 1'b0;
   localparam logic       ACT_ACCEPT = 1'b1;

   logic clock;
   logic reset;
   int   failures;
   int   pending;
   int   idle_pct;
   int   stall_pct;
   logic long_hold_req;
   int   hold_left;
   int   n_writes;
   int   n_packets;

   // Last values written per slot, used only to aim packets at rules
   logic [1:0]  hint_dir         [RULE_COUNT];
   logic [7:0]  hint_proto       [RULE_COUNT];
   logic [31:0] hint_src_addr    [RULE_COUNT];
   logic [15:0] hint_source_port [RULE_COUNT];
   logic [31:0] hint_dst_addr    [RULE_COUNT];
   logic [15:0] hint_dst_port    [RULE_COUNT];

   fmpf_chan_if #(.PAYLOAD_TYPE(fmpf_pkg::req_payload_type)) req_ch ();
   fmpf_chan_if #(.PAYLOAD_TYPE(fmpf_pkg::rsp_payload_type)) rsp_ch ();

   first_match_packet_filter_top #(.RULE_COUNT(RULE_COUNT)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   packet_verdict_checker #(.RULE_COUNT(RULE_COUNT)) verdict_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_ch.valid),
      .req_ready   (req_ch.ready),
      .req_payload (req_ch.payload),
      .rsp_valid   (rsp_ch.valid),
      .rsp_ready   (rsp_ch.ready),
      .rsp_payload (rsp_ch.payload),
      .failures    (failures),
      .outstanding (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Overall time limit
   initial begin
      #3_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // Receiver: random stalls, plus one long hold-off counted here
   initial begin
      rsp_ch.ready = 1'b0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (long_hold_req) begin
            hold_left = LONG_HOLD_CYCLES;
            long_hold_req = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   function automatic fmpf_pkg::req_payload_type random_fill();
      fmpf_pkg::req_payload_type it;
      it.opcode      = 1'($urandom_range(1));
      it.rule_slot   = 4'($urandom_range(15));
      it.direction   = 2'($urandom_range(3));
      it.protocol    = 8'($urandom_range(255));
      it.rule_action = 1'($urandom_range(1));
      it.src_addr    = $urandom;
      it.src_mask    = $urandom;
      it.source_port = 16'($urandom_range(65535));
      it.dst_addr    = $urandom;
      it.dst_mask    = $urandom;
      it.dst_port    = 16'($urandom_range(65535));
      return it;
   endfunction

   // Clean prefixes mostly; also zero, junk and masks with a zero right after the ones
   function automatic logic [31:0] random_mask();
      int pick;
      int len;
      pick = $urandom_range(99);
      len  = $urandom_range(32, 1);
      if (pick < 60) begin
         return ~(32'hFFFF_FFFF >> len);
      end else if (pick < 72) begin
         return '0;
      end else if (pick < 86) begin
         return ~(32'hFFFF_FFFF >> (len - 1)) | ($urandom >> len);
      end
      return $urandom;
   endfunction

   function automatic logic [31:0] random_flip();
      int pick;
      pick = $urandom_range(99);
      if (pick < 50) begin
         return '0;
      end else if (pick < 80) begin
         return $urandom >> $urandom_range(31, 8);
      end
      return $urandom;
   endfunction

   function automatic fmpf_pkg::req_payload_type random_rule();
      fmpf_pkg::req_payload_type it;
      it = random_fill();
      it.opcode = fmpf_pkg::OP_WRITE;
      if ($urandom_range(99) < 85) begin
         it.direction = 2'($urandom_range(2, 1));
      end
      if ($urandom_range(99) < 80) begin
         it.protocol = 8'($urandom_range(2));
      end
      if ($urandom_range(9) == 0) begin
         it.src_addr = '0;
      end
      if ($urandom_range(9) == 0) begin
         it.dst_addr = '0;
      end
      it.src_mask = random_mask();
      it.dst_mask = random_mask();
      if ($urandom_range(99) < 40) begin
         it.source_port = '0;
      end
      if ($urandom_range(99) < 40) begin
         it.dst_port = '0;
      end
      return it;
   endfunction

   // Most packets are aimed at a stored rule with a few bits disturbed
   function automatic fmpf_pkg::req_payload_type random_packet();
      fmpf_pkg::req_payload_type it;
      int                        s;
      it = random_fill();
      it.opcode = fmpf_pkg::OP_CLASSIFY;
      if ($urandom_range(99) < 80) begin
         s = $urandom_range(RULE_COUNT - 1);
         it.direction = (hint_dir[s] != fmpf_pkg::DIR_NONE) ? hint_dir[s]
                                                            : 2'($urandom_range(2, 1));
         if (hint_proto[s] == 8'(fmpf_pkg::RPROTO_TCP)) begin
            it.protocol = fmpf_pkg::PROTO_TCP;
         end else if (hint_proto[s] == 8'(fmpf_pkg::RPROTO_UDP)) begin
            it.protocol = fmpf_pkg::PROTO_UDP;
         end else if ($urandom_range(2) != 0) begin
            it.protocol = $urandom_range(1) ? fmpf_pkg::PROTO_TCP : fmpf_pkg::PROTO_UDP;
         end
         if ($urandom_range(9) == 0) begin
            it.protocol = 8'($urandom_range(255));
         end
         it.src_addr = hint_src_addr[s] ^ random_flip();
         it.dst_addr = hint_dst_addr[s] ^ random_flip();
         if (hint_source_port[s] != '0 && $urandom_range(3) != 0) begin
            it.source_port = hint_source_port[s];
         end
         if (hint_dst_port[s] != '0 && $urandom_range(3) != 0) begin
            it.dst_port = hint_dst_port[s];
         end
      end else if ($urandom_range(1) == 0) begin
         it.direction = 2'($urandom_range(2, 1));
      end
      return it;
   endfunction

   function automatic fmpf_pkg::req_payload_type rule_item(
      input logic [3:0] slot, input logic [1:0] dir, input logic [7:0] proto, input logic act,
      input logic [31:0] saddr, input logic [31:0] smask, input logic [15:0] sport,
      input logic [31:0] daddr, input logic [31:0] dmask, input logic [15:0] dport);
      fmpf_pkg::req_payload_type it;
      it = '{opcode: fmpf_pkg::OP_WRITE, rule_slot: slot, direction: dir, protocol: proto,
             rule_action: act, src_addr: saddr, src_mask: smask, source_port: sport,
             dst_addr: daddr, dst_mask: dmask, dst_port: dport};
      return it;
   endfunction

   // Fields that packets ignore are left random
   function automatic fmpf_pkg::req_payload_type packet_item(
      input logic [1:0] dir, input logic [7:0] proto, input logic [31:0] saddr,
      input logic [15:0] sport, input logic [31:0] daddr, input logic [15:0] dport);
      fmpf_pkg::req_payload_type it;
      it = random_fill();
      it.opcode      = fmpf_pkg::OP_CLASSIFY;
      it.direction   = dir;
      it.protocol    = proto;
      it.src_addr    = saddr;
      it.source_port = sport;
      it.dst_addr    = daddr;
      it.dst_port    = dport;
      return it;
   endfunction

   task automatic send_item(input fmpf_pkg::req_payload_type item);
      while ($urandom_range(99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.payload <= item;
      if (item.opcode == fmpf_pkg::OP_WRITE) begin
         n_writes++;
         hint_dir[item.rule_slot]         = item.direction;
         hint_proto[item.rule_slot]       = item.protocol;
         hint_src_addr[item.rule_slot]    = item.src_addr;
         hint_source_port[item.rule_slot] = item.source_port;
         hint_dst_addr[item.rule_slot]    = item.dst_addr;
         hint_dst_port[item.rule_slot]    = item.dst_port;
      end else begin
         n_packets++;
      end
      @(posedge clock);
      while (!req_ch.ready) begin
         @(posedge clock);
      end
   endtask

   task automatic run_random(input int count);
      repeat (count) begin
         if ($urandom_range(99) < 25) begin
            send_item(random_rule());
         end else begin
            send_item(random_packet());
         end
      end
   endtask

   // Drop valid and wait until every predicted verdict has come back
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) begin
         @(posedge clock);
      end
   endtask

   // Stimulus
   initial begin
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.payload = '0;
      idle_pct       = 0;
      stall_pct      = 0;
      long_hold_req  = 1'b0;
      n_writes       = 0;
      n_packets      = 0;
      foreach (hint_dir[i]) begin
         hint_dir[i]         = fmpf_pkg::DIR_NONE;
         hint_proto[i]       = '0;
         hint_src_addr[i]    = '0;
         hint_source_port[i] = '0;
         hint_dst_addr[i]    = '0;
         hint_dst_port[i]    = '0;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // empty table accepts by default; a packet with no direction never matches
      send_item(packet_item(DIR_IN, fmpf_pkg::PROTO_TCP, 32'h0A00_0001, 16'd1000,
                            32'h0102_0304, 16'd80));
      send_item(packet_item(fmpf_pkg::DIR_NONE, fmpf_pkg::PROTO_UDP, '0, '0, '0, '0));
      // tcp-only drop rule on a /8 source
      send_item(rule_item(4'd0, DIR_IN, 8'(fmpf_pkg::RPROTO_TCP), ACT_DROP, 32'h0A00_0000,
                          32'hFF00_0000, '0, '0, '0, 16'd80));
      send_item(packet_item(DIR_IN, fmpf_pkg::PROTO_TCP, 32'h0A01_0203, 16'd1000,
                            32'h0102_0304, 16'd80));
      send_item(packet_item(DIR_IN, fmpf_pkg::PROTO_UDP, 32'h0A01_0203, 16'd1000,
                            32'h0102_0304, 16'd80));
      // direction three, unknown protocol code, full compare from a zero mask, top slot
      send_item(rule_item(4'd15, DIR_ODD, 8'hFF, ACT_ACCEPT, '1, '0, '1, '1, '0, '1));
      send_item(packet_item(DIR_ODD, fmpf_pkg::PROTO_TCP, '1, '1, '1, '1));
      // non-tcp/udp packet: ports count as zero, so the port rule misses
      send_item(packet_item(DIR_ODD, 8'hFF, '1, '1, '1, '1));
      // mask with a leading zero makes the source a wildcard
      send_item(rule_item(4'd7, DIR_OUT, 8'(fmpf_pkg::RPROTO_UDP), ACT_DROP, 32'hC0A8_0000,
                          32'h7FFF_FFFF, '0, '0, '0, '0));
      send_item(packet_item(DIR_OUT, fmpf_pkg::PROTO_UDP, 32'h1234_5678, 16'd53,
                            32'h9ABC_DEF0, 16'd53));
      send_item(packet_item(DIR_OUT, fmpf_pkg::PROTO_TCP, 32'h1234_5678, 16'd53,
                            32'h9ABC_DEF0, 16'd53));
      // catch-all on a lower slot shadows slot 7
      send_item(rule_item(4'd3, DIR_OUT, 8'(fmpf_pkg::RPROTO_ANY), ACT_ACCEPT,
                          '0, '0, '0, '0, '0, '0));
      send_item(packet_item(DIR_OUT, PROTO_ICMP, 32'd1, 16'd2, 32'd3, 16'd4));
      send_item(packet_item(DIR_OUT, fmpf_pkg::PROTO_UDP, 32'h1234_5678, 16'd53,
                            32'h9ABC_DEF0, 16'd53));
      // protocol byte 6 is no rule code, stored as any
      send_item(rule_item(4'd4, DIR_IN, fmpf_pkg::PROTO_TCP, ACT_DROP, '0, '1, 16'd1234,
                          '0, '0, '0));
      send_item(packet_item(DIR_IN, PROTO_ICMP, 32'h0A00_0001, 16'd1234, '0, '0));
      send_item(packet_item(DIR_IN, fmpf_pkg::PROTO_UDP, 32'h0B00_0001, 16'd1234, '0, 16'd9));
      // disable slot 0, then /31 source and /32 destination boundaries
      send_item(rule_item(4'd0, fmpf_pkg::DIR_NONE, 8'(fmpf_pkg::RPROTO_UDP), ACT_ACCEPT,
                          '1, '1, '1, '1, '1, '1));
      send_item(rule_item(4'd1, DIR_IN, 8'(fmpf_pkg::RPROTO_UDP), ACT_ACCEPT, 32'h0A00_0001,
                          32'hFFFF_FFFE, '0, 32'h0102_0304, '1, '0));
      send_item(packet_item(DIR_IN, fmpf_pkg::PROTO_UDP, 32'h0A00_0000, 16'd7,
                            32'h0102_0304, 16'd8));
      send_item(packet_item(DIR_IN, fmpf_pkg::PROTO_UDP, 32'h0A00_0000, 16'd1234,
                            32'h0102_0305, 16'd8));
      send_item(packet_item(DIR_IN, fmpf_pkg::PROTO_TCP, 32'h0A00_0001, 16'd80,
                            32'h0102_0304, 16'd80));
      send_item(packet_item(fmpf_pkg::DIR_NONE, 8'd0, '0, '0, '0, '0));

      // random traffic over the idle and stall phases
      run_random(260);
      idle_pct = 54;
      run_random(260);
      idle_pct  = 0;
      stall_pct = 54;
      run_random(260);
      idle_pct  = 20;
      stall_pct = 20;
      run_random(260);

      // long receiver hold-off while items keep coming, then let the pipe drain
      idle_pct      = 0;
      stall_pct     = 0;
      long_hold_req = 1'b1;
      run_random(60);
      wait_drained();
      run_random(250);

      wait_drained();
      repeat (2 * (RULE_COUNT + 2)) @(posedge clock);
      $display("Covered %0d rule writes and %0d packets across idle, stall, hold-off and drain",
               n_writes, n_packets);
      if (failures == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
`default_nettype wire
